### rtl/prim_minimum_spanning_tree_top_defines.svh
// Assertion macros shared by the spanning tree engine.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef PRIM_MINIMUM_SPANNING_TREE_TOP_DEFINES_SVH
`define PRIM_MINIMUM_SPANNING_TREE_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PMST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("prim_mst check failed");

// Next-cycle implication, checked out of reset.
`define PMST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("prim_mst check failed");

`endif

### rtl/prim_mst_pkg.sv
// Types and constants of the spanning tree engine.
// No dependencies.
package prim_mst_pkg;
  localparam int unsigned NumVert = 16;
  localparam int unsigned VertW = 4;
  localparam int unsigned WeightW = 16;
  localparam int unsigned CountW = 5;
  localparam int unsigned PairW = 2 * VertW;
  localparam int unsigned NumPair = NumVert * NumVert;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_RUN   = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD2,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_e;

  typedef struct packed {
    logic                      start;
    logic                      restart;
    logic                      valid;
    logic [VertW-1:0]          v;
    logic                      present;
    logic                      in_tree;
    logic [VertW-1:0]          cur;
    logic signed [WeightW-1:0] w;
  } scan_ctl_t;

  typedef struct packed {
    logic                      found;
    logic [VertW-1:0]          pick;
    logic [VertW-1:0]          parent;
    logic signed [WeightW-1:0] key;
  } pick_t;
endpackage

### rtl/prim_minimum_spanning_tree_top.sv
// Top level of the Prim spanning tree engine: edge store, sequencer, output register.
// Depends on prim_mst_pkg, prim_mst_keys and the assertion macro header.
//
// Channel   Dir  tdata (low bit up)                     tuser       tlast
// s_axis    in   vertex_a, vertex_b, weight             op          -
// m_axis    out  tree_vertex, new_vertex, edge_weight   edge_valid  last
// cfg       in   cfg_wdata_i = vertex_count, written when cfg_we_i is high
//
// An add edge word writes one matrix half in ST_IDLE and the other in ST_ADD2; clear and ignored words
// stay in ST_IDLE. A run scans the vertices through the single read port of the weight memory,
// one vertex per cycle, once per tree edge and once more; a start outside the count goes to ST_DECIDE.
// Reset clears the presence bits at once; there is no clearing pass.
// Results wait in the output register; a full register stalls the sequencer.
`include "prim_minimum_spanning_tree_top_defines.svh"
module prim_minimum_spanning_tree_top import prim_mst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // vertex_a[3:0], vertex_b[7:4], weight[23:8]
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // tree_vertex[3:0], new_vertex[7:4], edge_weight[23:8]
  output logic        m_axis_tuser,  // edge_valid
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i
);
  state_e                    state_q, state_d;
  logic [CountW-1:0]         vcount_q, n_eff;
  logic [NumPair-1:0]        present_q, present_d;
  logic [NumVert-1:0]        in_tree_q, in_tree_d;
  logic [VertW-1:0]          cur_q, cur_d, v_q, v_d;
  logic [PairW-1:0]          add_idx_q, add_idx_d;
  logic signed [WeightW-1:0] add_w_q, add_w_d;
  logic signed [WeightW-1:0] wmem [NumPair];
  logic signed [WeightW-1:0] rd_q;
  logic                      mem_we;
  logic [PairW-1:0]          mem_waddr;
  logic signed [WeightW-1:0] mem_wdata;
  logic                      issue, start, restart;
  logic                      p_valid_q, p_present_q, p_in_tree_q;
  logic [VertW-1:0]          p_v_q;
  logic                      pend_valid_q, pend_valid_d;
  pick_t                     pend_q, pend_d;
  logic                      m_valid_q, m_valid_d, m_user_q, m_user_d, m_last_q, m_last_d;
  logic [23:0]               m_data_q, m_data_d;
  logic                      accept, out_free, a_ok, b_ok;
  logic [VertW-1:0]          in_a, in_b;
  logic signed [WeightW-1:0] in_w;
  op_e                       op;
  scan_ctl_t                 ctl;
  pick_t                     pick;

  assign n_eff  = (vcount_q > CountW'(NumVert)) ? CountW'(NumVert) : vcount_q;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign op     = op_e'(s_axis_tuser);
  assign in_a   = s_axis_tdata[3:0];
  assign in_b   = s_axis_tdata[7:4];
  assign in_w   = s_axis_tdata[23:8];
  assign a_ok   = {1'b0, in_a} < n_eff;
  assign b_ok   = {1'b0, in_b} < n_eff;
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d      = state_q;
    present_d    = present_q;
    in_tree_d    = in_tree_q;
    cur_d        = cur_q;
    v_d          = v_q;
    add_idx_d    = add_idx_q;
    add_w_d      = add_w_q;
    mem_we       = 1'b0;
    mem_waddr    = add_idx_q;
    mem_wdata    = add_w_q;
    issue        = 1'b0;
    start        = 1'b0;
    restart      = 1'b0;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_user_d     = m_user_q;
    m_data_d     = m_data_q;
    m_last_d     = m_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_ADD: begin
              if (a_ok && b_ok && !present_q[{in_a, in_b}]) begin
                mem_we    = 1'b1;
                mem_waddr = {in_a, in_b};
                mem_wdata = in_w;
                present_d[{in_a, in_b}] = 1'b1;
                present_d[{in_b, in_a}] = 1'b1;
                add_idx_d = {in_b, in_a};
                add_w_d   = in_w;
                state_d   = ST_ADD2;
              end
            end
            OP_CLEAR: present_d = '0;
            OP_RUN: begin
              start        = 1'b1;
              pend_valid_d = 1'b0;
              cur_d        = in_a;
              v_d          = '0;
              in_tree_d    = '0;
              if (a_ok) begin
                in_tree_d[in_a] = 1'b1;
                state_d = ST_SCAN;
              end else begin
                state_d = ST_DECIDE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ADD2: begin
        mem_we  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        issue = 1'b1;
        if (({1'b0, v_q} + CountW'(1)) == n_eff) begin
          state_d = ST_DRAIN;
        end else begin
          v_d = v_q + VertW'(1);
        end
      end
      ST_DRAIN: state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (out_free) begin
          if (pick.found) begin
            if (pend_valid_q) begin
              m_valid_d = 1'b1;
              m_user_d  = 1'b1;
              m_data_d  = {pend_q.key, pend_q.pick, pend_q.parent};
              m_last_d  = 1'b0;
            end
            pend_d       = pick;
            pend_valid_d = 1'b1;
            in_tree_d[pick.pick] = 1'b1;
            cur_d   = pick.pick;
            v_d     = '0;
            restart = 1'b1;
            state_d = ST_SCAN;
          end else begin
            m_valid_d = 1'b1;
            m_user_d  = pend_valid_q;
            m_data_d  = pend_valid_q ? {pend_q.key, pend_q.pick, pend_q.parent} : '0;
            m_last_d  = 1'b1;
            state_d   = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      vcount_q     <= CountW'(NumVert);
      present_q    <= '0;
      in_tree_q    <= '0;
      cur_q        <= '0;
      v_q          <= '0;
      p_valid_q    <= 1'b0;
      pend_valid_q <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      present_q    <= present_d;
      in_tree_q    <= in_tree_d;
      cur_q        <= cur_d;
      v_q          <= v_d;
      p_valid_q    <= issue;
      pend_valid_q <= pend_valid_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    add_idx_q   <= add_idx_d;
    add_w_q     <= add_w_d;
    p_v_q       <= v_q;
    p_present_q <= present_q[{cur_q, v_q}];
    p_in_tree_q <= in_tree_q[v_q];
    pend_q      <= pend_d;
    m_user_q    <= m_user_d;
    m_data_q    <= m_data_d;
    m_last_q    <= m_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      wmem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_q <= wmem[{cur_q, v_q}];
    end
  end

  always_comb begin
    ctl.start   = start;
    ctl.restart = restart;
    ctl.valid   = p_valid_q;
    ctl.v       = p_v_q;
    ctl.present = p_present_q;
    ctl.in_tree = p_in_tree_q;
    ctl.cur     = cur_q;
    ctl.w       = rd_q;
  end

  prim_mst_keys u_keys (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .pick_o (pick)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  `PMST_ASSERT_NOW(a_pick_outside_tree, (state_q == ST_DECIDE) && pick.found,
                   !in_tree_q[pick.pick])
  `PMST_ASSERT_NOW(a_scan_has_root, state_q == ST_SCAN, in_tree_q != '0)
  `PMST_ASSERT_NOW(a_lookup_in_scan, p_valid_q,
                   (state_q == ST_SCAN) || (state_q == ST_DRAIN))
endmodule

### rtl/prim_mst_keys.sv
// Per-vertex best key and parent store with the running minimum search.
// Depends on prim_mst_pkg.
module prim_mst_keys import prim_mst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  scan_ctl_t ctl_i,
  output pick_t     pick_o
);
  logic signed [WeightW-1:0] key_mem [NumVert];
  logic [VertW-1:0]          parent_mem [NumVert];
  logic [NumVert-1:0]        key_set_q, key_set_d;
  pick_t                     pick_q, pick_d;
  logic signed [WeightW-1:0] key_rd, new_key;
  logic [VertW-1:0]          par_rd, new_par;
  logic                      set_rd, cand, upd, elig;

  always_comb begin
    key_rd  = key_mem[ctl_i.v];
    par_rd  = parent_mem[ctl_i.v];
    set_rd  = key_set_q[ctl_i.v];
    cand    = ctl_i.valid && !ctl_i.in_tree && ctl_i.present;
    upd     = cand && (!set_rd || (ctl_i.w < key_rd));
    new_key = upd ? ctl_i.w : key_rd;
    new_par = upd ? ctl_i.cur : par_rd;
    elig    = ctl_i.valid && !ctl_i.in_tree && (set_rd || cand);
    key_set_d = key_set_q;
    if (ctl_i.start) begin
      key_set_d = '0;
    end else if (upd) begin
      key_set_d[ctl_i.v] = 1'b1;
    end
    pick_d = pick_q;
    if (ctl_i.start || ctl_i.restart) begin
      pick_d.found = 1'b0;
    end else if (elig && (!pick_q.found || (new_key < pick_q.key))) begin
      pick_d.found  = 1'b1;
      pick_d.pick   = ctl_i.v;
      pick_d.parent = new_par;
      pick_d.key    = new_key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_set_q <= '0;
      pick_q    <= '0;
    end else begin
      key_set_q <= key_set_d;
      pick_q    <= pick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      key_mem[ctl_i.v]    <= ctl_i.w;
      parent_mem[ctl_i.v] <= ctl_i.cur;
    end
  end

  assign pick_o = pick_q;
endmodule
